// File: rtl/core/oaat_pkg.sv
// oaat_pkg: shared constants and types for the one-at-a-time byte hash block
// no dependencies; used by oaat_front, oaat_fifo, oaat_back and the top level
package oaat_pkg;

	localparam int unsigned HASH_W       = 64;
	localparam int unsigned BYTE_W       = 8;
	localparam int unsigned BUCKET_W     = 32;
	localparam int unsigned DIV_STEPS    = HASH_W;
	localparam int unsigned DIV_CNT_W    = $clog2(DIV_STEPS);

	localparam int unsigned MIX_ADD_SH   = 10;
	localparam int unsigned MIX_XOR_SH   = 6;
	localparam int unsigned FIN_ADD1_SH  = 3;
	localparam int unsigned FIN_XOR_SH   = 11;
	localparam int unsigned FIN_ADD2_SH  = 15;

	localparam logic [BUCKET_W-1:0] BUCKET_COUNT_RESET = 32'd10000;

	typedef logic [HASH_W-1:0] hash_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

endpackage

// File: rtl/core/one_at_a_time_byte_hash_mod.sv
// one_at_a_time_byte_hash_mod: top level of the one-at-a-time string hash to bucket index
// depends on oaat_pkg, oaat_front, oaat_fifo, oaat_back
//
//   channel   direction  handshake              payload
//   in        input      in_valid / in_ready    byte_value, last_byte
//   out       output     out_valid / out_ready  bucket_index
//   cfg       input      cfg_wr_en              cfg_wr_data (bucket_count)
//
// one byte transaction per cycle while the hash queue has room
// each string then passes through the back end: pop, three avalanche steps,
// a one-bit-per-cycle modulo over all HASH_W hash bits, and a load into the output register
// the modulo loop sets the sustained rate for short strings
// arst_n clears the running hash, the queue and the output; bucket_count resets to 10000
// out stalls hold the back end in its hold state; the front keeps taking bytes until the queue fills
module one_at_a_time_byte_hash_mod #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [oaat_pkg::BYTE_W-1:0]       byte_value,
	input  logic                              last_byte,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [oaat_pkg::BUCKET_W-1:0]     bucket_index,
	input  logic                              cfg_wr_en,
	input  logic [oaat_pkg::BUCKET_W-1:0]     cfg_wr_data
);

	oaat_pkg::fifo_status_t fifo_status;
	oaat_pkg::hash_t        push_data;
	oaat_pkg::hash_t        pop_data;
	logic                   push;
	logic                   pop;

	oaat_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.byte_value  (byte_value),
		.last_byte   (last_byte),
		.fifo_status (fifo_status),
		.push        (push),
		.push_data   (push_data)
	);

	oaat_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (fifo_status)
	);

	oaat_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.fifo_status  (fifo_status),
		.pop_data     (pop_data),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.bucket_index (bucket_index)
	);

endmodule

// File: rtl/core/oaat_front.sv
// oaat_front: takes byte transactions and applies the per-byte mix
// depends on oaat_pkg; hands each finished string hash to oaat_fifo
module oaat_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [oaat_pkg::BYTE_W-1:0]       byte_value,
	input  logic                              last_byte,
	input  oaat_pkg::fifo_status_t            fifo_status,
	output logic                              push,
	output oaat_pkg::hash_t                   push_data
);

	oaat_pkg::hash_t hash_q;
	oaat_pkg::hash_t sum;
	oaat_pkg::hash_t mix_add;
	oaat_pkg::hash_t mix_out;
	logic            accept;

	assign in_ready = !fifo_status.full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		sum     = hash_q + {{(oaat_pkg::HASH_W-oaat_pkg::BYTE_W){byte_value[oaat_pkg::BYTE_W-1]}},
			byte_value};
		mix_add = sum + (sum << oaat_pkg::MIX_ADD_SH);
		mix_out = mix_add ^ (mix_add >> oaat_pkg::MIX_XOR_SH);
	end

	assign push      = accept && last_byte;
	assign push_data = mix_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
		end else if (accept) begin
			hash_q <= last_byte ? '0 : mix_out;
		end
	end

endmodule

// File: rtl/core/oaat_fifo.sv
// oaat_fifo: short queue of mixed string hashes between front and back
// depends on oaat_pkg for the hash and status types
module oaat_fifo #(
	parameter int unsigned DEPTH = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  oaat_pkg::hash_t        push_data,
	input  logic                   pop,
	output oaat_pkg::hash_t        pop_data,
	output oaat_pkg::fifo_status_t status
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	oaat_pkg::hash_t   mem [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign pop_data     = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!status.full || pop))
		else $error("queue written while full");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not follow a write");

endmodule

// File: rtl/core/oaat_back.sv
// oaat_back: final avalanche, bit-serial modulo and output register
// depends on oaat_pkg; pops string hashes from oaat_fifo, holds bucket_count
module oaat_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [oaat_pkg::BUCKET_W-1:0]     cfg_wr_data,
	input  oaat_pkg::fifo_status_t            fifo_status,
	input  oaat_pkg::hash_t                   pop_data,
	output logic                              pop,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [oaat_pkg::BUCKET_W-1:0]     bucket_index
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIN1,
		ST_FIN2,
		ST_FIN3,
		ST_DIV,
		ST_HOLD
	} state_t;

	state_t                               state_q;
	oaat_pkg::hash_t                      h_q;
	logic [oaat_pkg::BUCKET_W-1:0]        rem_q;
	logic [oaat_pkg::DIV_CNT_W-1:0]       cnt_q;
	logic [oaat_pkg::BUCKET_W-1:0]        bucket_q;
	logic                                 out_valid_q;
	logic [oaat_pkg::BUCKET_W-1:0]        result_q;
	logic [oaat_pkg::BUCKET_W:0]          trial;
	logic [oaat_pkg::BUCKET_W:0]          diff;
	logic                                 can_load;

	assign pop          = (state_q == ST_IDLE) && !fifo_status.empty;
	assign out_valid    = out_valid_q;
	assign bucket_index = result_q;
	assign can_load     = !out_valid_q || out_ready;

	// restoring remainder step, one dividend bit per cycle
	always_comb begin
		trial = {rem_q, h_q[oaat_pkg::HASH_W-1]};
		diff  = trial - {1'b0, bucket_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_q <= oaat_pkg::BUCKET_COUNT_RESET;
		end else if (cfg_wr_en) begin
			bucket_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			h_q         <= '0;
			rem_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			result_q    <= '0;
		end else begin
			if (out_valid_q && out_ready && (state_q != ST_HOLD)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!fifo_status.empty) begin
						h_q     <= pop_data;
						state_q <= ST_FIN1;
					end
				end
				ST_FIN1: begin
					h_q     <= h_q + (h_q << oaat_pkg::FIN_ADD1_SH);
					state_q <= ST_FIN2;
				end
				ST_FIN2: begin
					h_q     <= h_q ^ (h_q >> oaat_pkg::FIN_XOR_SH);
					state_q <= ST_FIN3;
				end
				ST_FIN3: begin
					h_q     <= h_q + (h_q << oaat_pkg::FIN_ADD2_SH);
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (trial >= {1'b0, bucket_q}) begin
						rem_q <= diff[oaat_pkg::BUCKET_W-1:0];
					end else begin
						rem_q <= trial[oaat_pkg::BUCKET_W-1:0];
					end
					h_q   <= h_q << 1;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == oaat_pkg::DIV_CNT_W'(oaat_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (can_load) begin
						result_q    <= (bucket_q == '0) ? '0 : rem_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_rem_below_mod: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && bucket_q != '0) |-> (rem_q < bucket_q))
		else $error("partial remainder not below bucket count");

	a_result_from_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_HOLD))
		else $error("result raised outside the hold state");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == oaat_pkg::DIV_CNT_W'(oaat_pkg::DIV_STEPS - 1))
		|=> (state_q == ST_HOLD))
		else $error("modulo did not finish after the last dividend bit");

endmodule
